// File: hdl/pfr_pkg.sv
// shared types and constants for the page frame replacement unit
package pfr_pkg;

    localparam int TOTAL_BITS = 32;
    localparam int PAGE_IN_BITS = 16;
    localparam int FRAME_OUT_BITS = 2;

    typedef enum logic [1:0] {
        ST_EMPTY = 2'd0,
        ST_UNREF = 2'd1,
        ST_REF   = 2'd2
    } t_status;

    typedef struct packed {
        logic hit;
        logic filled;
    } t_dec;

endpackage

// File: hdl/pfr_select.sv
// hit search, empty frame search and victim choice for one item
module pfr_select #(
    parameter int FRAMES    = 3,
    parameter int PAGE_BITS = 16,
    parameter int AGE_BITS  = 8,
    parameter int FW        = $clog2(FRAMES)
) (
    input  pfr_pkg::t_status       i_status   [FRAMES],
    input  logic [PAGE_BITS-1:0]   i_page     [FRAMES],
    input  logic [AGE_BITS-1:0]    i_age      [FRAMES],
    input  logic [PAGE_BITS-1:0]   i_req_page,
    output pfr_pkg::t_dec          o_dec,
    output logic [FW-1:0]          o_sel
);

    logic [FRAMES-1:0] match;
    logic [FRAMES-1:0] empty;
    logic [FW-1:0]     hit_idx;
    logic [FW-1:0]     empty_idx;
    logic [FW-1:0]     vic_idx;
    logic [AGE_BITS-1:0] best;

    always_comb begin
        for (int i = 0; i < FRAMES; i++) begin
            match[i] = (i_status[i] != pfr_pkg::ST_EMPTY) && (i_page[i] == i_req_page);
            empty[i] = (i_status[i] == pfr_pkg::ST_EMPTY);
        end
    end

    // lowest index wins
    always_comb begin
        hit_idx   = '0;
        empty_idx = '0;
        for (int i = FRAMES - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_idx = FW'(i);
            end
            if (empty[i]) begin
                empty_idx = FW'(i);
            end
        end
    end

    // oldest frame that was already unreferenced, strict compare from zero
    always_comb begin
        best    = '0;
        vic_idx = '0;
        for (int i = 0; i < FRAMES; i++) begin
            if (i_status[i] != pfr_pkg::ST_REF && i_age[i] > best) begin
                best    = i_age[i];
                vic_idx = FW'(i);
            end
        end
    end

    always_comb begin
        o_dec.hit    = |match;
        o_dec.filled = !(|match) && (|empty);
        if (|match) begin
            o_sel = hit_idx;
        end else if (|empty) begin
            o_sel = empty_idx;
        end else begin
            o_sel = vic_idx;
        end
    end

endmodule

// File: hdl/pfr_frames.sv
// frame table: page, age and status registers with their update
module pfr_frames #(
    parameter int FRAMES    = 3,
    parameter int PAGE_BITS = 16,
    parameter int AGE_BITS  = 8,
    parameter int FW        = $clog2(FRAMES)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_upd,
    input  pfr_pkg::t_dec          i_dec,
    input  logic [FW-1:0]          i_sel,
    input  logic [PAGE_BITS-1:0]   i_req_page,
    output pfr_pkg::t_status       o_status [FRAMES],
    output logic [PAGE_BITS-1:0]   o_page   [FRAMES],
    output logic [AGE_BITS-1:0]    o_age    [FRAMES]
);

    pfr_pkg::t_status     r_status [FRAMES];
    pfr_pkg::t_status     n_status [FRAMES];
    logic [AGE_BITS-1:0]  r_age    [FRAMES];
    logic [AGE_BITS-1:0]  n_age    [FRAMES];
    logic [PAGE_BITS-1:0] r_page   [FRAMES];
    logic [PAGE_BITS-1:0] n_page   [FRAMES];

    always_comb begin
        for (int j = 0; j < FRAMES; j++) begin
            n_status[j] = r_status[j];
            n_age[j]    = r_age[j];
            n_page[j]   = r_page[j];
            if (i_upd) begin
                if (i_sel == FW'(j)) begin
                    n_age[j] = '0;
                    if (i_dec.hit) begin
                        n_status[j] = pfr_pkg::ST_REF;
                    end else begin
                        n_status[j] = pfr_pkg::ST_UNREF;
                        n_page[j]   = i_req_page;
                    end
                end else begin
                    if (r_age[j] != '1) begin
                        n_age[j] = r_age[j] + 1'b1;
                    end
                    // eviction pass clears reference marks
                    if (!i_dec.hit && !i_dec.filled && r_status[j] == pfr_pkg::ST_REF) begin
                        n_status[j] = pfr_pkg::ST_UNREF;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < FRAMES; j++) begin
            r_page[j] <= n_page[j];
            if (!i_rst_n) begin
                r_status[j] <= pfr_pkg::ST_EMPTY;
                r_age[j]    <= '0;
            end else begin
                r_status[j] <= n_status[j];
                r_age[j]    <= n_age[j];
            end
        end
    end

    assign o_status = r_status;
    assign o_page   = r_page;
    assign o_age    = r_age;

endmodule

// File: hdl/page_frame_replacement_top.sv
// top level of the page frame replacement unit
// One page reference is taken per clock cycle and o_busy is always low, so
// i_start may be held high for a stream of items. Each item is registered at
// the input, then looked up and applied to the frame table in the following
// cycle. Its result is captured in the result register by the edge that applies
// the item, and is driven on the ports from there with o_valid high.
// The frame search and update run in one pass over all frames, so the rate is
// one item per cycle for any number of frames. The receiver cannot stall:
// every result is present for exactly the one cycle in which o_valid is high.
// Totals saturate at their maximum; reset clears frame status and age, not pages.
module page_frame_replacement_top #(
    parameter int FRAMES    = 3,
    parameter int PAGE_BITS = 16,
    parameter int AGE_BITS  = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [pfr_pkg::PAGE_IN_BITS-1:0]   i_page,
    output logic                               o_busy,
    output logic                               o_valid,
    output logic                               o_hit,
    output logic [pfr_pkg::FRAME_OUT_BITS-1:0] o_frame,
    output logic                               o_filled_empty,
    output logic [pfr_pkg::TOTAL_BITS-1:0]     o_total_hits,
    output logic [pfr_pkg::TOTAL_BITS-1:0]     o_total_faults
);

    localparam int FW = $clog2(FRAMES);

    logic                           r_in_vld;
    logic [PAGE_BITS-1:0]           r_in_page;
    logic                           r_out_vld;
    logic                           r_hit;
    logic                           r_filled;
    logic [FW-1:0]                  r_sel;
    logic [pfr_pkg::TOTAL_BITS-1:0] r_hit_total;
    logic [pfr_pkg::TOTAL_BITS-1:0] n_hit_total;
    logic [pfr_pkg::TOTAL_BITS-1:0] r_fault_total;
    logic [pfr_pkg::TOTAL_BITS-1:0] n_fault_total;

    pfr_pkg::t_status     fr_status [FRAMES];
    logic [PAGE_BITS-1:0] fr_page   [FRAMES];
    logic [AGE_BITS-1:0]  fr_age    [FRAMES];
    pfr_pkg::t_dec        dec;
    logic [FW-1:0]        sel;

    assign o_busy = 1'b0;

    // input register
    always_ff @(posedge i_clk) begin
        r_in_page <= PAGE_BITS'(i_page);
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= i_start;
        end
    end

    pfr_select #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS),
        .AGE_BITS  (AGE_BITS),
        .FW        (FW)
    ) u_select (
        .i_status   (fr_status),
        .i_page     (fr_page),
        .i_age      (fr_age),
        .i_req_page (r_in_page),
        .o_dec      (dec),
        .o_sel      (sel)
    );

    pfr_frames #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS),
        .AGE_BITS  (AGE_BITS),
        .FW        (FW)
    ) u_frames (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_upd      (r_in_vld),
        .i_dec      (dec),
        .i_sel      (sel),
        .i_req_page (r_in_page),
        .o_status   (fr_status),
        .o_page     (fr_page),
        .o_age      (fr_age)
    );

    always_comb begin
        n_hit_total   = r_hit_total;
        n_fault_total = r_fault_total;
        if (r_in_vld) begin
            if (dec.hit) begin
                if (r_hit_total != '1) begin
                    n_hit_total = r_hit_total + 1'b1;
                end
            end else begin
                if (r_fault_total != '1) begin
                    n_fault_total = r_fault_total + 1'b1;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        r_hit    <= dec.hit;
        r_filled <= dec.filled;
        r_sel    <= sel;
        if (!i_rst_n) begin
            r_out_vld     <= 1'b0;
            r_hit_total   <= '0;
            r_fault_total <= '0;
        end else begin
            r_out_vld     <= r_in_vld;
            r_hit_total   <= n_hit_total;
            r_fault_total <= n_fault_total;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_hit          = r_hit;
    assign o_frame        = pfr_pkg::FRAME_OUT_BITS'(r_sel);
    assign o_filled_empty = r_filled;
    assign o_total_hits   = r_hit_total;
    assign o_total_faults = r_fault_total;

`ifndef SYNTH
    a_valid_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, 2))
        else $error("result without an accepted item");

    a_frame_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_sel < FW'(FRAMES - 1)) || (r_sel == FW'(FRAMES - 1)))
        else $error("frame index out of range");

    a_hit_no_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> !o_filled_empty && o_total_faults == $past(o_total_faults))
        else $error("hit changed fault state");

    a_fault_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_total_hits == $past(o_total_hits)
            && (o_total_faults != $past(o_total_faults) || o_total_faults == '1))
        else $error("fault count not advanced");
`endif

endmodule

// File: tb/tb.sv
// testbench for the page frame replacement unit: directed and random page streams
`timescale 1ns / 1ps

module tb;

    localparam int NUM_FRAMES  = 3;
    localparam int PG_BITS     = pfr_pkg::PAGE_IN_BITS;
    localparam int AGE_W       = 8;
    localparam int CNT_BITS    = pfr_pkg::TOTAL_BITS;
    localparam int CYCLE_LIMIT = 100000;
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        logic                             hit;
        logic [pfr_pkg::FRAME_OUT_BITS-1:0] frame;
        logic                             filled;
        logic [CNT_BITS-1:0]              hits;
        logic [CNT_BITS-1:0]              faults;
    } t_outcome;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_start;
    logic [PG_BITS-1:0]                 i_page;
    logic                               o_busy;
    logic                               o_valid;
    logic                               o_hit;
    logic [pfr_pkg::FRAME_OUT_BITS-1:0] o_frame;
    logic                               o_filled_empty;
    logic [CNT_BITS-1:0]                o_total_hits;
    logic [CNT_BITS-1:0]                o_total_faults;

    logic [PG_BITS-1:0]  tbl_page   [NUM_FRAMES];
    logic [AGE_W-1:0]    tbl_age    [NUM_FRAMES];
    pfr_pkg::t_status    tbl_status [NUM_FRAMES];
    logic [CNT_BITS-1:0] hit_tally;
    logic [CNT_BITS-1:0] fault_tally;
    t_outcome            pending_q[$];
    t_outcome            want;

    int idle_pct;
    int items_sent;
    int results_checked;
    int mismatch_count;
    int age_sat_seen;
    int cycle_count;

    page_frame_replacement_top #(
        .FRAMES   (NUM_FRAMES),
        .PAGE_BITS(PG_BITS),
        .AGE_BITS (AGE_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_page        (i_page),
        .o_busy        (o_busy),
        .o_valid       (o_valid),
        .o_hit         (o_hit),
        .o_frame       (o_frame),
        .o_filled_empty(o_filled_empty),
        .o_total_hits  (o_total_hits),
        .o_total_faults(o_total_faults)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic clear_table();
        int i;
        for (i = 0; i < NUM_FRAMES; i++) begin
            tbl_page[i]   = '0;
            tbl_age[i]    = '0;
            tbl_status[i] = pfr_pkg::ST_EMPTY;
        end
        hit_tally   = '0;
        fault_tally = '0;
    endtask

    function automatic t_outcome apply_reference(input logic [PG_BITS-1:0] pg);
        t_outcome        r;
        int              sel;
        int              i;
        logic [AGE_W-1:0] best;
        r   = '0;
        sel = -1;
        for (i = 0; i < NUM_FRAMES; i++) begin
            if (sel < 0 && tbl_status[i] != pfr_pkg::ST_EMPTY && tbl_page[i] == pg)
                sel = i;
        end
        if (sel >= 0) begin
            r.hit           = 1'b1;
            tbl_status[sel] = pfr_pkg::ST_REF;
            tbl_age[sel]    = '0;
            if (hit_tally != '1)
                hit_tally++;
        end else begin
            if (fault_tally != '1)
                fault_tally++;
            for (i = 0; i < NUM_FRAMES; i++) begin
                if (sel < 0 && tbl_status[i] == pfr_pkg::ST_EMPTY) begin
                    sel      = i;
                    r.filled = 1'b1;
                end
            end
            if (sel < 0) begin
                best = '0;
                sel  = 0;
                for (i = 0; i < NUM_FRAMES; i++) begin
                    if (tbl_status[i] == pfr_pkg::ST_REF) begin
                        tbl_status[i] = pfr_pkg::ST_UNREF;
                    end else if (tbl_age[i] > best) begin
                        best = tbl_age[i];
                        sel  = i;
                    end
                end
            end
            tbl_page[sel]   = pg;
            tbl_status[sel] = pfr_pkg::ST_UNREF;
            tbl_age[sel]    = '0;
        end
        for (i = 0; i < NUM_FRAMES; i++) begin
            if (i != sel && tbl_age[i] != '1) begin
                tbl_age[i]++;
                if (tbl_age[i] == '1)
                    age_sat_seen++;
            end
        end
        r.frame  = 2'(sel);
        r.hits   = hit_tally;
        r.faults = fault_tally;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task automatic send_page(input logic [PG_BITS-1:0] pg);
        while ($urandom_range(0, 99) < idle_pct) begin
            @(negedge i_clk);
            i_start <= 1'b0;
            i_page  <= PG_BITS'($urandom);
        end
        @(negedge i_clk);
        i_start <= 1'b1;
        i_page  <= pg;
        @(posedge i_clk);
        while (o_busy)
            @(posedge i_clk);
        pending_q.push_back(apply_reference(pg));
        items_sent++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_q.size() == 0) begin
                report_mismatch("result with no item pending");
            end else begin
                want = pending_q.pop_front();
                results_checked++;
                if (o_hit !== want.hit)
                    report_mismatch($sformatf("hit got %b want %b", o_hit, want.hit));
                if (o_frame !== want.frame)
                    report_mismatch($sformatf("frame got %0d want %0d", o_frame, want.frame));
                if (o_filled_empty !== want.filled)
                    report_mismatch($sformatf("filled_empty got %b want %b",
                                              o_filled_empty, want.filled));
                if (o_total_hits !== want.hits)
                    report_mismatch($sformatf("total_hits got %0d want %0d",
                                              o_total_hits, want.hits));
                if (o_total_faults !== want.faults)
                    report_mismatch($sformatf("total_faults got %0d want %0d",
                                              o_total_faults, want.faults));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_q.size());
            $display("FAIL page_frame_replacement_top");
            $finish;
        end
    end

    // page 0 matches the model's cleared entry of an empty frame but must still miss
    task automatic test_empty_never_matches();
        send_page(16'h0000);
        send_page(16'h0000);
    endtask

    task automatic test_fill_extremes();
        send_page(16'hFFFF);
        send_page(16'h8000);
        send_page(16'hFFFF);
        send_page(16'h0001);
        send_page(16'h7FFF);
    endtask

    task automatic test_victim_choice();
        send_page(16'h5555);
        send_page(16'hAAAA);
        send_page(16'h5555);
        send_page(16'h1234);
        send_page(16'hAAAA);
        send_page(16'hFEDC);
    endtask

    // every frame referenced: marks cleared and the victim falls back to frame 0
    task automatic test_all_referenced();
        int i;
        for (i = 0; i < NUM_FRAMES; i++)
            send_page(tbl_page[i]);
        send_page(16'h0F0F);
        send_page(16'hF0F0);
    endtask

    // hammer two resident pages until the third frame's age saturates, then miss
    task automatic test_age_saturation(input int n);
        logic [PG_BITS-1:0] hot_a;
        logic [PG_BITS-1:0] hot_b;
        int                 k;
        hot_a = tbl_page[0];
        hot_b = tbl_page[1];
        for (k = 0; k < n; k++)
            send_page($urandom_range(0, 1) ? hot_a : hot_b);
        send_page(PG_BITS'($urandom));
        send_page(PG_BITS'($urandom));
    endtask

    task automatic test_random_stream(input int pct, input int n);
        logic [PG_BITS-1:0] pool [5];
        int                 k;
        idle_pct = pct;
        for (k = 0; k < 5; k++)
            pool[k] = PG_BITS'($urandom);
        pool[0] = '0;
        pool[1] = '1;
        for (k = 0; k < n; k++) begin
            if (k % 40 == 39)
                pool[$urandom_range(0, 4)] = PG_BITS'($urandom);
            if ($urandom_range(0, 99) < 12)
                send_page(PG_BITS'($urandom));
            else if ($urandom_range(0, 99) < 30)
                send_page(tbl_page[$urandom_range(0, NUM_FRAMES - 1)]);
            else
                send_page(pool[$urandom_range(0, 4)]);
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_start         = 1'b0;
        i_page          = '0;
        idle_pct        = 0;
        items_sent      = 0;
        results_checked = 0;
        mismatch_count  = 0;
        age_sat_seen    = 0;
        cycle_count     = 0;
        clear_table();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_never_matches();
        test_fill_extremes();
        test_victim_choice();
        test_all_referenced();

        test_random_stream(0, 300);
        test_age_saturation(280);
        test_random_stream(84, 280);
        test_random_stream(20, 290);

        @(negedge i_clk);
        i_start <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_q.size()));

        $display("%0d page references sent under three pacing mixes, %0d results checked",
                 items_sent, results_checked);
        $display("totals reached %0d hits and %0d faults, %0d frame ages saturated",
                 hit_tally, fault_tally, age_sat_seen);
        if (mismatch_count == 0) begin
            $display("PASS page_frame_replacement_top");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("FAIL page_frame_replacement_top");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/pfr_pkg.sv
hdl/pfr_select.sv
hdl/pfr_frames.sv
hdl/page_frame_replacement_top.sv
tb/tb.sv
